// ----- rtl/core/cpuex_pkg.sv -----
// Package for the eight-bit execute unit: request and response payload types,
// command codes, status bit positions and reset values.
// No dependencies.
package cpuex_pkg;

	typedef struct packed {
		logic [5:0]        command;
		logic [7:0]        operand;
		logic              acc_mode;
		logic [15:0]       pc_now;
		logic signed [7:0] branch_offset;
	} exec_req_t;

	typedef struct packed {
		logic [7:0]  write_data;
		logic        write_enable;
		logic [8:0]  stack_address;
		logic        branch_taken;
		logic [15:0] branch_target;
		logic [7:0]  acc_out;
		logic [7:0]  x_out;
		logic [7:0]  y_out;
		logic [7:0]  sp_out;
		logic [7:0]  status_out;
	} exec_rsp_t;

	localparam logic [5:0] CMD_ADC = 6'd0;
	localparam logic [5:0] CMD_SBC = 6'd1;
	localparam logic [5:0] CMD_AND = 6'd2;
	localparam logic [5:0] CMD_ORA = 6'd3;
	localparam logic [5:0] CMD_EOR = 6'd4;
	localparam logic [5:0] CMD_CMP = 6'd5;
	localparam logic [5:0] CMD_CPX = 6'd6;
	localparam logic [5:0] CMD_CPY = 6'd7;
	localparam logic [5:0] CMD_BIT = 6'd8;
	localparam logic [5:0] CMD_LDA = 6'd9;
	localparam logic [5:0] CMD_LDX = 6'd10;
	localparam logic [5:0] CMD_LDY = 6'd11;
	localparam logic [5:0] CMD_ASL = 6'd12;
	localparam logic [5:0] CMD_LSR = 6'd13;
	localparam logic [5:0] CMD_ROL = 6'd14;
	localparam logic [5:0] CMD_ROR = 6'd15;
	localparam logic [5:0] CMD_INC = 6'd16;
	localparam logic [5:0] CMD_DEC = 6'd17;
	localparam logic [5:0] CMD_INX = 6'd18;
	localparam logic [5:0] CMD_INY = 6'd19;
	localparam logic [5:0] CMD_DEX = 6'd20;
	localparam logic [5:0] CMD_DEY = 6'd21;
	localparam logic [5:0] CMD_STA = 6'd22;
	localparam logic [5:0] CMD_STX = 6'd23;
	localparam logic [5:0] CMD_STY = 6'd24;
	localparam logic [5:0] CMD_TAX = 6'd25;
	localparam logic [5:0] CMD_TAY = 6'd26;
	localparam logic [5:0] CMD_TSX = 6'd27;
	localparam logic [5:0] CMD_TXA = 6'd28;
	localparam logic [5:0] CMD_TXS = 6'd29;
	localparam logic [5:0] CMD_TYA = 6'd30;
	localparam logic [5:0] CMD_CLC = 6'd31;
	localparam logic [5:0] CMD_CLD = 6'd32;
	localparam logic [5:0] CMD_CLI = 6'd33;
	localparam logic [5:0] CMD_CLV = 6'd34;
	localparam logic [5:0] CMD_SEC = 6'd35;
	localparam logic [5:0] CMD_SED = 6'd36;
	localparam logic [5:0] CMD_SEI = 6'd37;
	localparam logic [5:0] CMD_BCC = 6'd38;
	localparam logic [5:0] CMD_BCS = 6'd39;
	localparam logic [5:0] CMD_BEQ = 6'd40;
	localparam logic [5:0] CMD_BMI = 6'd41;
	localparam logic [5:0] CMD_BNE = 6'd42;
	localparam logic [5:0] CMD_BPL = 6'd43;
	localparam logic [5:0] CMD_BVC = 6'd44;
	localparam logic [5:0] CMD_BVS = 6'd45;
	localparam logic [5:0] CMD_PHA = 6'd46;
	localparam logic [5:0] CMD_PHP = 6'd47;
	localparam logic [5:0] CMD_PLA = 6'd48;
	localparam logic [5:0] CMD_PLP = 6'd49;
	localparam logic [5:0] CMD_DCP = 6'd50;
	localparam logic [5:0] CMD_ISB = 6'd51;
	localparam logic [5:0] CMD_SLO = 6'd52;

	localparam int FLAG_C = 0;
	localparam int FLAG_Z = 1;
	localparam int FLAG_I = 2;
	localparam int FLAG_D = 3;
	localparam int FLAG_B = 4;
	localparam int FLAG_U = 5;
	localparam int FLAG_V = 6;
	localparam int FLAG_N = 7;

	localparam logic [7:0] SP_RESET     = 8'hFD;
	localparam logic [7:0] STATUS_RESET = 8'h24;

endpackage

// ----- rtl/core/eight_bit_cpu_execute_unit.sv -----
// Execute unit of an eight-bit processor: architectural registers, ALU, flag
// update, stack and branch address generation.
// Depends on cpuex_pkg.
//
// Usage: the request channel (req_valid, req_stall, req) carries one data
// operation per transfer; the response channel (rsp_valid, rsp_stall, rsp)
// returns exactly one result per request, in order.
// A request is captured in an input register; in the next cycle the ALU and
// flag logic work on it together with the A, X, Y, SP and status registers,
// and, when the output register can advance, the result is written into it
// while the registers are updated and rsp_valid rises. Throughput is one
// operation per cycle while the receiver does not stall; the only loop is
// the path from the architectural registers through the ALU back to
// themselves. When the receiver stalls, the output register holds its result;
// the input register still takes a request if it is empty, and req_stall
// rises while it holds one.
// Reset clears both valid flags and sets A, X and Y to zero, SP to FD hex
// and the status byte to 24 hex.
module eight_bit_cpu_execute_unit
	import cpuex_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  exec_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output exec_rsp_t rsp
);

	logic      req_valid_s1;
	exec_req_t req_s1;
	logic      rsp_valid_s2;
	exec_rsp_t rsp_s2;

	logic [7:0] acc_q, x_q, y_q, sp_q, status_q;
	logic [7:0] acc_d, x_d, y_d, sp_d, status_d;

	logic advance;
	logic fire;

	logic [7:0] m;
	logic       carry_in;
	logic [7:0] m_inc, m_dec;
	logic [7:0] add_val;
	logic [8:0] add_sum;
	logic       add_ovf;
	logic [7:0] cmp_reg, cmp_val;
	logic [8:0] cmp_diff;
	logic [7:0] shift_src;
	logic [7:0] shift_res;
	logic       shift_carry;
	logic [7:0] sp_inc, sp_dec;
	logic [15:0] target;
	logic       cond;
	exec_rsp_t  res;

	// The output register advances when empty or when its result is taken.
	assign advance   = !rsp_valid_s2 || !rsp_stall;
	assign fire      = req_valid_s1 && advance;
	assign req_stall = req_valid_s1 && !advance;

	assign m        = req_s1.operand;
	assign carry_in = status_q[FLAG_C];
	assign m_inc    = m + 8'd1;
	assign m_dec    = m - 8'd1;
	assign sp_inc   = sp_q + 8'd1;
	assign sp_dec   = sp_q - 8'd1;
	assign target   = req_s1.pc_now + {{8{req_s1.branch_offset[7]}}, req_s1.branch_offset};

	// Shared adder: ADC adds the operand, SBC its complement and ISB the complement of the incremented operand.
	always_comb begin
		if (req_s1.command == CMD_ADC) begin
			add_val = m;
		end else if (req_s1.command == CMD_SBC) begin
			add_val = ~m;
		end else begin
			add_val = ~m_inc;
		end
	end
	assign add_sum = {1'b0, acc_q} + {1'b0, add_val} + {8'd0, carry_in};
	assign add_ovf = (~(acc_q[7] ^ add_val[7])) & (acc_q[7] ^ add_sum[7]);

	// Shared comparator; DCP compares with the decremented operand.
	always_comb begin
		if (req_s1.command == CMD_CPX) begin
			cmp_reg = x_q;
		end else if (req_s1.command == CMD_CPY) begin
			cmp_reg = y_q;
		end else begin
			cmp_reg = acc_q;
		end
	end
	assign cmp_val  = (req_s1.command == CMD_DCP) ? m_dec : m;
	assign cmp_diff = {1'b0, cmp_reg} - {1'b0, cmp_val};

	assign shift_src = req_s1.acc_mode ? acc_q : m;
	always_comb begin
		case (req_s1.command)
			CMD_ASL: begin
				shift_res   = {shift_src[6:0], 1'b0};
				shift_carry = shift_src[7];
			end
			CMD_LSR: begin
				shift_res   = {1'b0, shift_src[7:1]};
				shift_carry = shift_src[0];
			end
			CMD_ROL: begin
				shift_res   = {shift_src[6:0], carry_in};
				shift_carry = shift_src[7];
			end
			default: begin
				shift_res   = {carry_in, shift_src[7:1]};
				shift_carry = shift_src[0];
			end
		endcase
	end

	always_comb begin
		case (req_s1.command)
			CMD_BCC: cond = !status_q[FLAG_C];
			CMD_BCS: cond = status_q[FLAG_C];
			CMD_BEQ: cond = status_q[FLAG_Z];
			CMD_BMI: cond = status_q[FLAG_N];
			CMD_BNE: cond = !status_q[FLAG_Z];
			CMD_BPL: cond = !status_q[FLAG_N];
			CMD_BVC: cond = !status_q[FLAG_V];
			default: cond = status_q[FLAG_V];
		endcase
	end

	always_comb begin
		acc_d    = acc_q;
		x_d      = x_q;
		y_d      = y_q;
		sp_d     = sp_q;
		status_d = status_q;
		res      = '0;
		unique case (req_s1.command) inside
			CMD_ADC, CMD_SBC: begin
				acc_d            = add_sum[7:0];
				status_d[FLAG_C] = add_sum[8];
				status_d[FLAG_V] = add_ovf;
				status_d[FLAG_N] = add_sum[7];
				status_d[FLAG_Z] = (add_sum[7:0] == 8'd0);
			end
			CMD_AND, CMD_ORA, CMD_EOR: begin
				if (req_s1.command == CMD_AND) begin
					acc_d = acc_q & m;
				end else if (req_s1.command == CMD_ORA) begin
					acc_d = acc_q | m;
				end else begin
					acc_d = acc_q ^ m;
				end
				status_d[FLAG_N] = acc_d[7];
				status_d[FLAG_Z] = (acc_d == 8'd0);
			end
			CMD_CMP, CMD_CPX, CMD_CPY: begin
				status_d[FLAG_C] = !cmp_diff[8];
				status_d[FLAG_N] = cmp_diff[7];
				status_d[FLAG_Z] = (cmp_diff[7:0] == 8'd0);
			end
			CMD_BIT: begin
				status_d[FLAG_Z] = ((acc_q & m) == 8'd0);
				status_d[FLAG_N] = m[7];
				status_d[FLAG_V] = m[6];
			end
			CMD_LDA, CMD_LDX, CMD_LDY, CMD_PLA: begin
				if (req_s1.command == CMD_LDX) begin
					x_d = m;
				end else if (req_s1.command == CMD_LDY) begin
					y_d = m;
				end else begin
					acc_d = m;
				end
				if (req_s1.command == CMD_PLA) begin
					sp_d              = sp_inc;
					res.stack_address = {1'b1, sp_inc};
				end
				status_d[FLAG_N] = m[7];
				status_d[FLAG_Z] = (m == 8'd0);
			end
			CMD_ASL, CMD_LSR, CMD_ROL, CMD_ROR: begin
				status_d[FLAG_C] = shift_carry;
				status_d[FLAG_N] = shift_res[7];
				status_d[FLAG_Z] = (shift_res == 8'd0);
				if (req_s1.acc_mode) begin
					acc_d = shift_res;
				end else begin
					res.write_data   = shift_res;
					res.write_enable = 1'b1;
				end
			end
			CMD_INC, CMD_DEC: begin
				res.write_data   = (req_s1.command == CMD_INC) ? m_inc : m_dec;
				res.write_enable = 1'b1;
				status_d[FLAG_N] = res.write_data[7];
				status_d[FLAG_Z] = (res.write_data == 8'd0);
			end
			CMD_INX, CMD_DEX, CMD_TAX, CMD_TSX: begin
				if (req_s1.command == CMD_INX) begin
					x_d = x_q + 8'd1;
				end else if (req_s1.command == CMD_DEX) begin
					x_d = x_q - 8'd1;
				end else if (req_s1.command == CMD_TAX) begin
					x_d = acc_q;
				end else begin
					x_d = sp_q;
				end
				status_d[FLAG_N] = x_d[7];
				status_d[FLAG_Z] = (x_d == 8'd0);
			end
			CMD_INY, CMD_DEY, CMD_TAY: begin
				if (req_s1.command == CMD_INY) begin
					y_d = y_q + 8'd1;
				end else if (req_s1.command == CMD_DEY) begin
					y_d = y_q - 8'd1;
				end else begin
					y_d = acc_q;
				end
				status_d[FLAG_N] = y_d[7];
				status_d[FLAG_Z] = (y_d == 8'd0);
			end
			CMD_TXA, CMD_TYA: begin
				acc_d            = (req_s1.command == CMD_TXA) ? x_q : y_q;
				status_d[FLAG_N] = acc_d[7];
				status_d[FLAG_Z] = (acc_d == 8'd0);
			end
			CMD_STA: begin
				res.write_data   = acc_q;
				res.write_enable = 1'b1;
			end
			CMD_STX: begin
				res.write_data   = x_q;
				res.write_enable = 1'b1;
			end
			CMD_STY: begin
				res.write_data   = y_q;
				res.write_enable = 1'b1;
			end
			CMD_TXS: sp_d = x_q;
			CMD_CLC: status_d[FLAG_C] = 1'b0;
			CMD_CLD: status_d[FLAG_D] = 1'b0;
			CMD_CLI: status_d[FLAG_I] = 1'b0;
			CMD_CLV: status_d[FLAG_V] = 1'b0;
			CMD_SEC: status_d[FLAG_C] = 1'b1;
			CMD_SED: status_d[FLAG_D] = 1'b1;
			CMD_SEI: status_d[FLAG_I] = 1'b1;
			[CMD_BCC:CMD_BVS]: begin
				res.branch_taken  = cond;
				res.branch_target = target;
			end
			CMD_PHA: begin
				res.stack_address = {1'b1, sp_q};
				res.write_data    = acc_q;
				res.write_enable  = 1'b1;
				sp_d              = sp_dec;
			end
			CMD_PHP: begin
				// The pushed copy carries B and U set; the live B flag is cleared.
				res.stack_address = {1'b1, sp_q};
				res.write_data    = status_q | 8'h30;
				res.write_enable  = 1'b1;
				sp_d              = sp_dec;
				status_d[FLAG_B]  = 1'b0;
			end
			CMD_PLP: begin
				sp_d              = sp_inc;
				res.stack_address = {1'b1, sp_inc};
				status_d          = m;
				status_d[FLAG_B]  = 1'b0;
			end
			CMD_DCP: begin
				res.write_data   = m_dec;
				res.write_enable = 1'b1;
				status_d[FLAG_C] = !cmp_diff[8];
				status_d[FLAG_N] = cmp_diff[7];
				status_d[FLAG_Z] = (cmp_diff[7:0] == 8'd0);
			end
			CMD_ISB: begin
				res.write_data   = m_inc;
				res.write_enable = 1'b1;
				acc_d            = add_sum[7:0];
				status_d[FLAG_C] = add_sum[8];
				status_d[FLAG_V] = add_ovf;
				status_d[FLAG_N] = add_sum[7];
				status_d[FLAG_Z] = (add_sum[7:0] == 8'd0);
			end
			CMD_SLO: begin
				res.write_data   = {m[6:0], 1'b0};
				res.write_enable = 1'b1;
				acc_d            = acc_q | {m[6:0], 1'b0};
				status_d[FLAG_C] = m[7];
				status_d[FLAG_N] = acc_d[7];
				status_d[FLAG_Z] = (acc_d == 8'd0);
			end
			default: begin
			end
		endcase
		status_d[FLAG_U] = 1'b1;
		res.acc_out      = acc_d;
		res.x_out        = x_d;
		res.y_out        = y_d;
		res.sp_out       = sp_d;
		res.status_out   = status_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			rsp_valid_s2 <= 1'b0;
			acc_q        <= 8'd0;
			x_q          <= 8'd0;
			y_q          <= 8'd0;
			sp_q         <= SP_RESET;
			status_q     <= STATUS_RESET;
		end else begin
			if (!req_stall) begin
				req_valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_s2 <= req_valid_s1;
			end
			if (fire) begin
				acc_q    <= acc_d;
				x_q      <= x_d;
				y_q      <= y_d;
				sp_q     <= sp_d;
				status_q <= status_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
		if (fire) begin
			rsp_s2 <= res;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

endmodule

// ----- rtl/core/cpuex_checker.sv -----
// Port-level checker for the eight-bit execute unit, bound to that module.
// Depends on cpuex_pkg and eight_bit_cpu_execute_unit.
module cpuex_checker
	import cpuex_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_stall,
	input exec_req_t req,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input exec_rsp_t rsp
);

	// A stalled result stays in place until the transfer completes.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// The unused status bit reads as one in every result.
	a_u_bit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status_out[FLAG_U])
		else $error("status U bit clear in result");

	// No write means no write data.
	a_wd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.write_enable |-> rsp.write_data == 8'd0)
		else $error("write data without write enable");

	// A stack address, where one is given, always lies in page one.
	a_stack_page: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.stack_address != 9'd0 |-> rsp.stack_address[8])
		else $error("stack address outside page one");

	// The input side never stalls while the output side is free to move.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("request stalled while output register empty");

endmodule

bind eight_bit_cpu_execute_unit cpuex_checker u_cpuex_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
